FILE: rtl/jang_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle package
// Shared widths, constants, the CORDIC step table and the stage payload types.
// ----------------------------------------------------------------------------
package jang_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int ANGLE_W          = 16;
  localparam int NORM_MSB         = 28;
  localparam int XY_W             = 32;
  localparam int Z_W              = 26;
  localparam int FRAC_DROP        = 8;
  localparam int MAX_COMP_W       = 31;

  localparam logic signed [Z_W-1:0] DEG90_Q16  = Z_W'(5898240);
  localparam logic signed [Z_W-1:0] DEG180_Q16 = Z_W'(11796480);
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(128);

  localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [ATAN_LEN] = '{
    Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
    Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
    Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
    Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
    Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
    Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
  };

  // Width of one vector component after the prescale.
  function automatic int comp_w(input int cb);
    return ((cb + 1) > MAX_COMP_W) ? MAX_COMP_W : (cb + 1);
  endfunction

  // Width of the unsigned dot and cross magnitudes.
  function automatic int prod_w(input int cb);
    return 2 * comp_w(cb);
  endfunction

  typedef struct packed {
    logic degen;
    logic vanish;
  } flags_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    flags_t                 flags;
  } cordic_t;

endpackage

FILE: rtl/jang_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle front end
// Forms the two side vectors, multiplies them out into dot and cross products
// and folds the pair into the first quadrant over four pipeline stages.
// ----------------------------------------------------------------------------
module jang_front #(
  parameter int COORD_BITS = jang_pkg::COORD_BITS_DEF,
  localparam int PW = jang_pkg::prod_w(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_vld,
  output logic                         up_rdy,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  output logic                         dn_vld,
  input  logic                         dn_rdy,
  output logic [PW-1:0]                dn_px,
  output logic [PW-1:0]                dn_py,
  output logic signed [jang_pkg::Z_W-1:0] dn_z0,
  output jang_pkg::flags_t             dn_flags
);
  import jang_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int CW  = comp_w(COORD_BITS);
  localparam int PRE = DW - CW;
  localparam int SW  = PW + 1;

  logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [DW-1:0] dux, duy, dvx, dvy;
  logic signed [CW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic                 dg1_r, dg2_r, dg3_r, dg_nxt;
  logic signed [PW-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [SW-1:0] dot_r, crs_r, crs_abs, ndot;
  logic [PW-1:0]        px_r, py_r, px_nxt, py_nxt;
  logic signed [Z_W-1:0] z0_r, z0_nxt;
  flags_t               flg_r, flg_nxt;
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic                 en1, en2, en3, en4;

  assign en4    = !v4_r || dn_rdy;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign up_rdy = en1;

  always_comb begin
    ax  = DW'(a_x);
    ay  = DW'(a_y);
    bx  = DW'(b_x);
    by  = DW'(b_y);
    cx  = DW'(c_x);
    cy  = DW'(c_y);
    dux = ax - bx;
    duy = ay - by;
    dvx = cx - bx;
    dvy = cy - by;
    dg_nxt = ((dux == '0) && (duy == '0)) || ((dvx == '0) && (dvy == '0));
  end

  always_comb begin
    crs_abs = crs_r[SW-1] ? -crs_r : crs_r;
    ndot    = -dot_r;
    flg_nxt.degen  = dg3_r;
    flg_nxt.vanish = (dot_r == '0) && (crs_r == '0);
    if (dot_r[SW-1]) begin
      px_nxt = crs_abs[PW-1:0];
      py_nxt = ndot[PW-1:0];
      z0_nxt = DEG90_Q16;
    end else begin
      px_nxt = dot_r[PW-1:0];
      py_nxt = crs_abs[PW-1:0];
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= up_vld;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_vld) begin
      ux_r  <= dux[DW-1:PRE];
      uy_r  <= duy[DW-1:PRE];
      vx_r  <= dvx[DW-1:PRE];
      vy_r  <= dvy[DW-1:PRE];
      dg1_r <= dg_nxt;
    end
    if (en2 && v1_r) begin
      m1_r  <= PW'(ux_r) * PW'(vx_r);
      m2_r  <= PW'(uy_r) * PW'(vy_r);
      m3_r  <= PW'(ux_r) * PW'(vy_r);
      m4_r  <= PW'(uy_r) * PW'(vx_r);
      dg2_r <= dg1_r;
    end
    if (en3 && v2_r) begin
      dot_r <= SW'(m1_r) + SW'(m2_r);
      crs_r <= SW'(m3_r) - SW'(m4_r);
      dg3_r <= dg2_r;
    end
    if (en4 && v3_r) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      z0_r  <= z0_nxt;
      flg_r <= flg_nxt;
    end
  end

  assign dn_vld   = v4_r;
  assign dn_px    = px_r;
  assign dn_py    = py_r;
  assign dn_z0    = z0_r;
  assign dn_flags = flg_r;

endmodule

FILE: rtl/jang_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle normalizer
// Finds the leading one of the larger magnitude, then shifts both magnitudes
// so that it lands on bit 28, over two pipeline stages.
// ----------------------------------------------------------------------------
module jang_norm #(
  parameter int COORD_BITS = jang_pkg::COORD_BITS_DEF,
  localparam int PW = jang_pkg::prod_w(COORD_BITS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_vld,
  output logic                            up_rdy,
  input  logic [PW-1:0]                   up_px,
  input  logic [PW-1:0]                   up_py,
  input  logic signed [jang_pkg::Z_W-1:0] up_z0,
  input  jang_pkg::flags_t                up_flags,
  output logic                            dn_vld,
  input  logic                            dn_rdy,
  output jang_pkg::cordic_t               dn_data
);
  import jang_pkg::*;

  localparam int LW = $clog2(PW);
  localparam int EW = PW + NORM_MSB;

  logic [PW-1:0]         m, px_r, py_r;
  logic [LW-1:0]         lead_nxt, lead_r;
  logic signed [Z_W-1:0] z0_r;
  flags_t                flg_r;
  logic [EW-1:0]         wide_x, wide_y;
  cordic_t               out_nxt, out_r;
  logic                  v1_r, v2_r, en1, en2;

  assign en2    = !v2_r || dn_rdy;
  assign en1    = !v1_r || en2;
  assign up_rdy = en1;

  always_comb begin
    m        = up_px | up_py;
    lead_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (m[i]) begin
        lead_nxt = LW'(i);
      end
    end
  end

  always_comb begin
    wide_x        = {px_r, {NORM_MSB{1'b0}}} >> lead_r;
    wide_y        = {py_r, {NORM_MSB{1'b0}}} >> lead_r;
    out_nxt.x     = XY_W'(wide_x[NORM_MSB:0]);
    out_nxt.y     = XY_W'(wide_y[NORM_MSB:0]);
    out_nxt.z     = z0_r;
    out_nxt.flags = flg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= up_vld;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_vld) begin
      px_r   <= up_px;
      py_r   <= up_py;
      lead_r <= lead_nxt;
      z0_r   <= up_z0;
      flg_r  <= up_flags;
    end
    if (en2 && v1_r) begin
      out_r <= out_nxt;
    end
  end

  assign dn_vld  = v2_r;
  assign dn_data = out_r;

endmodule

FILE: rtl/jang_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle CORDIC
// Unrolled vectoring CORDIC with one rotation per stage, followed by the
// clamp, rounding and output register.
// ----------------------------------------------------------------------------
module jang_cordic #(
  parameter int CORDIC_STEPS = jang_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_vld,
  output logic                          up_rdy,
  input  jang_pkg::cordic_t             up_data,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic [jang_pkg::ANGLE_W-1:0]  out_angle,
  output logic                          out_degen
);
  import jang_pkg::*;

  localparam int NS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  cordic_t               stg_in [NS];
  cordic_t               stg_nxt [NS];
  cordic_t               stg_r [NS];
  logic [NS-1:0]         vld_in, vld_r, en;
  logic                  en_out, out_vld_r, degen_r, degen_nxt;
  logic [ANGLE_W-1:0]    angle_r, angle_nxt;
  logic signed [Z_W-1:0] zf, zc, rnd;

  assign en_out = !out_vld_r || out_rdy;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [XY_W-1:0] xi, yi, xs, ys;
    logic signed [Z_W-1:0]  zi;

    if (k == 0) begin : g_first
      assign stg_in[k] = up_data;
      assign vld_in[k] = up_vld;
    end else begin : g_next
      assign stg_in[k] = stg_r[k-1];
      assign vld_in[k] = vld_r[k-1];
    end

    if (k == NS - 1) begin : g_last_en
      assign en[k] = !vld_r[k] || en_out;
    end else begin : g_mid_en
      assign en[k] = !vld_r[k] || en[k+1];
    end

    always_comb begin
      xi = stg_in[k].x;
      yi = stg_in[k].y;
      zi = stg_in[k].z;
      xs = xi >>> k;
      ys = yi >>> k;
      stg_nxt[k].flags = stg_in[k].flags;
      if (yi > 0) begin
        stg_nxt[k].x = xi + ys;
        stg_nxt[k].y = yi - xs;
        stg_nxt[k].z = zi + ATAN_DEG_Q16[k];
      end else begin
        stg_nxt[k].x = xi - ys;
        stg_nxt[k].y = yi + xs;
        stg_nxt[k].z = zi - ATAN_DEG_Q16[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && vld_in[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign up_rdy = en[0];

  always_comb begin
    zf = stg_r[NS-1].z;
    if (zf < 0) begin
      zc = '0;
    end else if (zf > DEG180_Q16) begin
      zc = DEG180_Q16;
    end else begin
      zc = zf;
    end
    rnd       = zc + ROUND_HALF;
    degen_nxt = stg_r[NS-1].flags.degen;
    if (stg_r[NS-1].flags.degen || stg_r[NS-1].flags.vanish) begin
      angle_nxt = '0;
    end else begin
      angle_nxt = rnd[FRAC_DROP +: ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en_out) begin
      out_vld_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && vld_r[NS-1]) begin
      angle_r <= angle_nxt;
      degen_r <= degen_nxt;
    end
  end

  assign out_vld   = out_vld_r;
  assign out_angle = angle_r;
  assign out_degen = degen_r;

endmodule

FILE: rtl/joint_angle_from_three_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle from three points
// Angle ABC at the vertex in Q8.8 degrees, computed as atan2(|cross|, dot)
// with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while the output is not stalled; the
// depth is set by one CORDIC rotation per stage. Empty stages fill while the
// output is stalled, so the input stalls only once every stage holds a word.
// Synchronous reset clears the valid bits of all stages; data registers are
// not reset.
module joint_angle_from_three_points #(
  parameter int COORD_BITS   = jang_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = jang_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   in_point_a_x,
  input  logic signed [COORD_BITS-1:0]   in_point_a_y,
  input  logic signed [COORD_BITS-1:0]   in_vertex_x,
  input  logic signed [COORD_BITS-1:0]   in_vertex_y,
  input  logic signed [COORD_BITS-1:0]   in_point_c_x,
  input  logic signed [COORD_BITS-1:0]   in_point_c_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [jang_pkg::ANGLE_W-1:0]   out_angle_degrees,
  output logic                           out_degenerate
);
  import jang_pkg::*;

  localparam int PW = prod_w(COORD_BITS);

  logic                  front_rdy, fn_vld, fn_rdy, nc_vld, nc_rdy;
  logic [PW-1:0]         fn_px, fn_py;
  logic signed [Z_W-1:0] fn_z0;
  flags_t                fn_flags;
  cordic_t               nc_data;

  assign in_stall = !front_rdy;

  jang_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (in_valid),
    .up_rdy   (front_rdy),
    .a_x      (in_point_a_x),
    .a_y      (in_point_a_y),
    .b_x      (in_vertex_x),
    .b_y      (in_vertex_y),
    .c_x      (in_point_c_x),
    .c_y      (in_point_c_y),
    .dn_vld   (fn_vld),
    .dn_rdy   (fn_rdy),
    .dn_px    (fn_px),
    .dn_py    (fn_py),
    .dn_z0    (fn_z0),
    .dn_flags (fn_flags)
  );

  jang_norm #(
    .COORD_BITS(COORD_BITS)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (fn_vld),
    .up_rdy   (fn_rdy),
    .up_px    (fn_px),
    .up_py    (fn_py),
    .up_z0    (fn_z0),
    .up_flags (fn_flags),
    .dn_vld   (nc_vld),
    .dn_rdy   (nc_rdy),
    .dn_data  (nc_data)
  );

  jang_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (nc_vld),
    .up_rdy    (nc_rdy),
    .up_data   (nc_data),
    .out_vld   (out_valid),
    .out_rdy   (!out_stall),
    .out_angle (out_angle_degrees),
    .out_degen (out_degenerate)
  );

endmodule

FILE: rtl/jang_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle port checker
// Watches the top-level ports for range, degenerate and backpressure rules.
// ----------------------------------------------------------------------------
module jang_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [jang_pkg::ANGLE_W-1:0]  out_angle_degrees,
  input logic                          out_degenerate
);
  import jang_pkg::*;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(46080);

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output word valid right after reset.");

  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_degrees <= ANGLE_MAX)
    else $error("Angle above 180 degrees.");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> out_angle_degrees == '0)
    else $error("Degenerate word carries a nonzero angle.");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output is free.");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_angle_degrees) && $stable(out_degenerate)))
    else $error("Stalled output word changed.");

endmodule

bind joint_angle_from_three_points jang_chk u_jang_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_angle_degrees (out_angle_degrees),
  .out_degenerate    (out_degenerate)
);

FILE: tb/joint_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle result checker
// Watches both channels of the joint angle block. Each accepted point triple
// is turned into an expected angle by a bit-exact CORDIC model, and each
// accepted result word is compared against the oldest expected angle.
// ----------------------------------------------------------------------------
module joint_angle_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic                                        in_stall,
  input  logic signed [jang_pkg::COORD_BITS_DEF-1:0]  in_point_a_x,
  input  logic signed [jang_pkg::COORD_BITS_DEF-1:0]  in_point_a_y,
  input  logic signed [jang_pkg::COORD_BITS_DEF-1:0]  in_vertex_x,
  input  logic signed [jang_pkg::COORD_BITS_DEF-1:0]  in_vertex_y,
  input  logic signed [jang_pkg::COORD_BITS_DEF-1:0]  in_point_c_x,
  input  logic signed [jang_pkg::COORD_BITS_DEF-1:0]  in_point_c_y,
  input  logic                                        out_valid,
  input  logic                                        out_stall,
  input  logic [jang_pkg::ANGLE_W-1:0]                out_angle_degrees,
  input  logic                                        out_degenerate,
  output int                                          fail_count,
  output int                                          pending_words
);

  localparam int STEPS = jang_pkg::CORDIC_STEPS_DEF;
  localparam longint unsigned NORM_TOP = 64'd1 << (jang_pkg::NORM_MSB + 1);
  localparam longint unsigned NORM_BOT = 64'd1 << jang_pkg::NORM_MSB;

  typedef struct {
    logic [jang_pkg::ANGLE_W-1:0] angle;
    logic                         degenerate;
  } joint_angle_t;

  joint_angle_t expected_angles[$];
  int           mismatches = 0;

  function automatic joint_angle_t predict_joint_angle(
    input logic signed [jang_pkg::COORD_BITS_DEF-1:0] ax,
    input logic signed [jang_pkg::COORD_BITS_DEF-1:0] ay,
    input logic signed [jang_pkg::COORD_BITS_DEF-1:0] bx,
    input logic signed [jang_pkg::COORD_BITS_DEF-1:0] by,
    input logic signed [jang_pkg::COORD_BITS_DEF-1:0] cx,
    input logic signed [jang_pkg::COORD_BITS_DEF-1:0] cy
  );
    longint          ux, uy, vx, vy, dot_p, cross_p, x, y, xs, ys, z;
    longint unsigned px, py, m;
    int              i;
    joint_angle_t    r;
    r.angle      = '0;
    r.degenerate = 1'b0;
    ux = longint'(ax) - longint'(bx);
    uy = longint'(ay) - longint'(by);
    vx = longint'(cx) - longint'(bx);
    vy = longint'(cy) - longint'(by);
    if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) begin
      r.degenerate = 1'b1;
      return r;
    end
    dot_p   = ux * vx + uy * vy;
    cross_p = ux * vy - uy * vx;
    if (cross_p < 0) begin
      cross_p = -cross_p;
    end
    if (dot_p == 0 && cross_p == 0) begin
      return r;
    end
    if (dot_p < 0) begin
      px = longint'(cross_p);
      py = longint'(-dot_p);
      z  = longint'(jang_pkg::DEG90_Q16);
    end else begin
      px = longint'(dot_p);
      py = longint'(cross_p);
      z  = 0;
    end
    m = px | py;
    while (m >= NORM_TOP) begin
      px = px >> 1;
      py = py >> 1;
      m  = m >> 1;
    end
    while (m < NORM_BOT) begin
      px = px << 1;
      py = py << 1;
      m  = m << 1;
    end
    x = longint'(px);
    y = longint'(py);
    for (i = 0; i < STEPS && i < jang_pkg::ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(jang_pkg::ATAN_DEG_Q16[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(jang_pkg::ATAN_DEG_Q16[i]);
      end
    end
    if (z < 0) begin
      z = 0;
    end
    if (z > longint'(jang_pkg::DEG180_Q16)) begin
      z = longint'(jang_pkg::DEG180_Q16);
    end
    r.angle = jang_pkg::ANGLE_W'((z + 128) >>> jang_pkg::FRAC_DROP);
    return r;
  endfunction

  always @(posedge clk) begin
    joint_angle_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected result word: angle_degrees %0d, degenerate %0d",
                 out_angle_degrees, out_degenerate);
          mismatches++;
        end else begin
          want = expected_angles.pop_front();
          if (out_angle_degrees !== want.angle) begin
            $error("angle_degrees: expected %0d, actual %0d", want.angle,
                   out_angle_degrees);
            mismatches++;
          end
          if (out_degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, actual %0d", want.degenerate,
                   out_degenerate);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_angles.push_back(predict_joint_angle(in_point_a_x, in_point_a_y,
                                                      in_vertex_x, in_vertex_y,
                                                      in_point_c_x, in_point_c_y));
      end
    end
    fail_count    <= mismatches;
    pending_words <= expected_angles.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint angle block testbench
// Drives directed and random point triples into the joint angle block under
// several sender idle and receiver stall mixes, and reports the verdict from
// the checker's failure and pending word counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB          = jang_pkg::COORD_BITS_DEF;
  localparam int LATENCY     = 7 + jang_pkg::CORDIC_STEPS_DEF;
  localparam int DRAIN       = 3 * LATENCY;
  localparam int PHASE_WORDS = 160;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CB-1:0] in_point_a_x = '0;
  logic signed [CB-1:0] in_point_a_y = '0;
  logic signed [CB-1:0] in_vertex_x = '0;
  logic signed [CB-1:0] in_vertex_y = '0;
  logic signed [CB-1:0] in_point_c_x = '0;
  logic signed [CB-1:0] in_point_c_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [jang_pkg::ANGLE_W-1:0] out_angle_degrees;
  logic                 out_degenerate;

  int fail_count;
  int pending_words;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  joint_angle_from_three_points u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_point_a_x      (in_point_a_x),
    .in_point_a_y      (in_point_a_y),
    .in_vertex_x       (in_vertex_x),
    .in_vertex_y       (in_vertex_y),
    .in_point_c_x      (in_point_c_x),
    .in_point_c_y      (in_point_c_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_angle_degrees (out_angle_degrees),
    .out_degenerate    (out_degenerate)
  );

  joint_angle_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_point_a_x      (in_point_a_x),
    .in_point_a_y      (in_point_a_y),
    .in_vertex_x       (in_vertex_x),
    .in_vertex_y       (in_vertex_y),
    .in_point_c_x      (in_point_c_x),
    .in_point_c_y      (in_point_c_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_angle_degrees (out_angle_degrees),
    .out_degenerate    (out_degenerate),
    .fail_count        (fail_count),
    .pending_words     (pending_words)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic int pick(input int lo, input int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic send_word(input int ax, input int ay, input int bx, input int by,
                           input int cx, input int cy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_point_a_x <= CB'(ax);
    in_point_a_y <= CB'(ay);
    in_vertex_x  <= CB'(bx);
    in_vertex_y  <= CB'(by);
    in_point_c_x <= CB'(cx);
    in_point_c_y <= CB'(cy);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    int bx, by, dx, dy, k1, k2;
    bx = pick(-32768, 32767);
    by = pick(-32768, 32767);
    dx = pick(-200, 200);
    dy = pick(-200, 200);
    k1 = pick(1, 100);
    k2 = pick(1, 100);
    case ($urandom_range(9))
      0, 1, 2: send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      3, 4: send_word(bx + pick(-8, 8), by + pick(-8, 8), bx, by,
                      bx + pick(-8, 8), by + pick(-8, 8));
      5: begin
        if ($urandom_range(1)) begin
          send_word(bx, by, bx, by, $urandom, $urandom);
        end else begin
          send_word($urandom, $urandom, bx, by, bx, by);
        end
      end
      6: send_word(bx + k1 * dx, by + k1 * dy, bx, by, bx + k2 * dx, by + k2 * dy);
      7: send_word(bx + k1 * dx, by + k1 * dy, bx, by, bx - k2 * dx, by - k2 * dy);
      8: send_word(bx + k1 * dx, by + k1 * dy, bx, by, bx - k2 * dy, by + k2 * dx);
      default: send_word(pick_extreme(), pick_extreme(), pick_extreme(),
                         pick_extreme(), pick_extreme(), pick_extreme());
    endcase
  endtask

  initial begin
    int phase;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_word(0, 0, 0, 0, 0, 0);
    send_word(500, -300, 500, -300, 20, 40);
    send_word(-700, 90, 1234, 4321, 1234, 4321);
    send_word(32767, 32767, -32768, -32768, 32767, -32768);
    send_word(-32768, -32768, 32767, 32767, -32768, 32767);
    send_word(16, 0, 0, 0, 32, 0);
    send_word(16, 0, 0, 0, -16, 0);
    send_word(16, 0, 0, 0, 0, 16);
    send_word(32767, 0, -32768, 0, -32768, 32767);
    send_word(10, 0, 0, 0, -10, 1);
    send_word(10, 0, 0, 0, 10, 1);
    send_word(1, 0, 0, 0, 0, 1);
    send_word(1, 0, 0, 0, -1, 0);
    send_word(1, 0, 0, 0, 1, 0);
    send_word(100, 0, 0, 0, 100, 100);
    send_word(100, 0, 0, 0, -100, 100);
    send_word(32767, 0, 0, 0, -32768, 1);
    send_word(32767, 0, 0, 0, 32767, 1);
    send_word(-1, -1, 32767, 32767, -32768, -32768);
    send_word(0, -32768, 0, 32767, 0, -32768);
    send_word(-32768, 32767, 32767, -32768, 32767, 32767);
    wait_for_results();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        send_random_word();
      end
      wait_for_results();
    end

    stall_pct = 0;
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/jang_pkg.sv
rtl/jang_front.sv
rtl/jang_norm.sv
rtl/jang_cordic.sv
rtl/joint_angle_from_three_points.sv
rtl/jang_chk.sv
tb/joint_angle_checker.sv
tb/testbench.sv
